// ----- rtl/qsud_pkg.sv -----
// Package for the quoted string unescape decoder.
// Holds the phase and result kind codes, error codes, register addresses and the job record.
// No dependencies.
package qsud_pkg;

    localparam logic [7:0] QUOTE_RESET  = 8'h22;
    localparam logic [7:0] BACKTICK     = 8'h60;
    localparam logic [7:0] BACKSLASH    = 8'h5C;
    localparam logic [7:0] NEWLINE      = 8'h0A;
    localparam int         QUEUE_DEPTH  = 4;
    localparam int         QPTR_W       = $clog2(QUEUE_DEPTH);

    // Register index decode (paddr[2])
    localparam logic REG_QUOTE = 1'b0;
    localparam logic REG_ALLOW = 1'b1;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_NO_OPEN  = 3'd1;
    localparam logic [2:0] ERR_NO_CLOSE = 3'd2;
    localparam logic [2:0] ERR_NEWLINE  = 3'd3;
    localparam logic [2:0] ERR_BAD_X    = 3'd4;
    localparam logic [2:0] ERR_BAD_U4   = 3'd5;
    localparam logic [2:0] ERR_BAD_U8   = 3'd6;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        PH_SEEK   = 4'd0,
        PH_BODY   = 4'd1,
        PH_SKIPWS = 4'd2,
        PH_ESC    = 4'd3,
        PH_OCT    = 4'd4,
        PH_HEX2   = 4'd5,
        PH_HEX4   = 4'd6,
        PH_HEX8   = 4'd7,
        PH_HALT   = 4'd8
    } t_phase;

    typedef struct packed {
        t_kind       kind;
        logic [2:0]  err;
        logic [7:0]  data;
    } t_res;

    // All results caused by one input item
    typedef struct packed {
        logic [2:0]  cnt;
        logic [31:0] pos;
        t_res [3:0]  res;
    } t_job;

endpackage

// ----- rtl/qsud_front.sv -----
// Front end: accepts source bytes, runs the string/escape state machine and
// builds one job record (up to four results) per byte. Depends on qsud_pkg.
module qsud_front import qsud_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    input  logic [7:0]  i_quote,
    input  logic        i_allow_nl,
    input  logic        i_full,
    output logic        o_push,
    output t_job        o_job
);

    typedef struct packed {
        t_phase ph;
        logic   emit;
        t_res   res;
    } t_body;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_dc, n_dc;
    logic [31:0] r_acc, n_acc;
    logic [31:0] r_idx, n_idx;
    t_job        w_job;
    logic        w_take;

    function automatic t_res mk_data(input logic [7:0] d);
        t_res r;
        r.kind = KIND_DATA;
        r.err  = ERR_NONE;
        r.data = d;
        return r;
    endfunction

    function automatic t_res mk_err(input logic [2:0] e);
        t_res r;
        r.kind = KIND_ERR;
        r.err  = e;
        r.data = 8'h00;
        return r;
    endfunction

    function automatic t_body body_step(input logic [7:0] b, input logic [7:0] q,
                                        input logic allow);
        t_body o;
        o.ph   = PH_BODY;
        o.emit = 1'b0;
        o.res  = mk_data(b);
        if (b == BACKSLASH) begin
            o.ph = PH_ESC;
        end else if (b == NEWLINE) begin
            if (!allow) begin
                o.ph   = PH_HALT;
                o.emit = 1'b1;
                o.res  = mk_err(ERR_NEWLINE);
            end else if (q != BACKTICK) begin
                o.ph = PH_SKIPWS;
            end else begin
                o.emit = 1'b1;
            end
        end else if (b == q) begin
            o.ph       = PH_HALT;
            o.emit     = 1'b1;
            o.res.kind = KIND_END;
            o.res.data = 8'h00;
        end else begin
            o.emit = 1'b1;
        end
        return o;
    endfunction

    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] v;
        v = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = {1'b1, b[3:0]};
        end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
            v = {1'b1, b[3:0] + 4'd9};
        end
        return v;
    endfunction

    function automatic t_job utf8(input logic [31:0] cp);
        t_job j;
        j = '0;
        if (cp < 32'h80) begin
            j.cnt    = 3'd1;
            j.res[0] = mk_data(cp[7:0]);
        end else if (cp < 32'h800) begin
            j.cnt    = 3'd2;
            j.res[0] = mk_data({3'b110, cp[10:6]});
            j.res[1] = mk_data({2'b10, cp[5:0]});
        end else if (cp < 32'h10000) begin
            j.cnt    = 3'd3;
            j.res[0] = mk_data({4'b1110, cp[15:12]});
            j.res[1] = mk_data({2'b10, cp[11:6]});
            j.res[2] = mk_data({2'b10, cp[5:0]});
        end else if (cp <= 32'h10FFFF) begin
            j.cnt    = 3'd4;
            j.res[0] = mk_data({5'b11110, cp[20:18]});
            j.res[1] = mk_data({2'b10, cp[17:12]});
            j.res[2] = mk_data({2'b10, cp[11:6]});
            j.res[3] = mk_data({2'b10, cp[5:0]});
        end else begin
            j.cnt    = 3'd3;
            j.res[0] = mk_data(8'hEF);
            j.res[1] = mk_data(8'hBF);
            j.res[2] = mk_data(8'hBD);
        end
        return j;
    endfunction

    always_comb begin
        t_body      bs;
        logic [4:0] hv;
        logic [3:0] dc1;
        logic [7:0] oct;
        logic [31:0] hacc;
        logic       done;
        logic [2:0] hex_err;

        n_phase = r_phase;
        n_dc    = r_dc;
        n_acc   = r_acc;
        n_idx   = r_idx + 32'd1;
        w_job   = '0;
        bs      = body_step(i_byte, i_quote, i_allow_nl);
        hv      = hex_val(i_byte);
        dc1     = r_dc + 4'd1;
        oct     = {r_acc[4:0], i_byte[2:0]};
        hacc    = {r_acc[27:0], hv[3:0]};
        done    = 1'b0;
        hex_err = ERR_BAD_X;

        unique case (r_phase) inside
            PH_SEEK: begin
                if (i_byte == i_quote) n_phase = PH_BODY;
            end
            PH_BODY: begin
                n_phase    = bs.ph;
                w_job.cnt  = {2'b00, bs.emit};
                w_job.res[0] = bs.res;
            end
            PH_SKIPWS: begin
                if (!((i_byte >= 8'h09 && i_byte <= 8'h0D) || i_byte == 8'h20)) begin
                    n_phase      = bs.ph;
                    w_job.cnt    = {2'b00, bs.emit};
                    w_job.res[0] = bs.res;
                end
            end
            PH_ESC: begin
                n_phase = PH_BODY;
                n_dc    = 4'd0;
                n_acc   = 32'd0;
                w_job.cnt = 3'd1;
                unique case (i_byte) inside
                    8'h61: w_job.res[0] = mk_data(8'd7);
                    8'h62: w_job.res[0] = mk_data(8'd8);
                    8'h74: w_job.res[0] = mk_data(8'd9);
                    8'h6E: w_job.res[0] = mk_data(8'd10);
                    8'h76: w_job.res[0] = mk_data(8'd11);
                    8'h66: w_job.res[0] = mk_data(8'd12);
                    8'h72: w_job.res[0] = mk_data(8'd13);
                    8'h78, 8'h58: begin
                        n_phase   = PH_HEX2;
                        w_job.cnt = 3'd0;
                    end
                    8'h75: begin
                        n_phase   = PH_HEX4;
                        w_job.cnt = 3'd0;
                    end
                    8'h55: begin
                        n_phase   = PH_HEX8;
                        w_job.cnt = 3'd0;
                    end
                    [8'h30:8'h37]: begin
                        n_phase   = PH_OCT;
                        n_acc     = {29'd0, i_byte[2:0]};
                        n_dc      = 4'd1;
                        w_job.cnt = 3'd0;
                    end
                    default: w_job.res[0] = mk_data(i_byte);
                endcase
            end
            PH_OCT: begin
                if (i_byte >= 8'h30 && i_byte <= 8'h37) begin
                    n_acc = {24'd0, oct};
                    n_dc  = dc1;
                    if (dc1 >= 4'd3) begin
                        w_job.cnt    = 3'd1;
                        w_job.res[0] = mk_data(oct);
                        n_phase      = PH_BODY;
                        n_dc         = 4'd0;
                        n_acc        = 32'd0;
                    end
                end else begin
                    w_job.res[0] = mk_data(r_acc[7:0]);
                    w_job.res[1] = bs.res;
                    w_job.cnt    = bs.emit ? 3'd2 : 3'd1;
                    n_phase      = bs.ph;
                    n_dc         = 4'd0;
                    n_acc        = 32'd0;
                end
            end
            PH_HEX2, PH_HEX4, PH_HEX8: begin
                if (r_phase == PH_HEX4) hex_err = ERR_BAD_U4;
                if (r_phase == PH_HEX8) hex_err = ERR_BAD_U8;
                if (!hv[4]) begin
                    w_job.cnt    = 3'd1;
                    w_job.res[0] = mk_err(hex_err);
                    n_phase      = PH_HALT;
                end else begin
                    n_acc = hacc;
                    n_dc  = dc1;
                    if (r_phase == PH_HEX2) done = (dc1 >= 4'd2);
                    else if (r_phase == PH_HEX4) done = (dc1 >= 4'd4);
                    else done = (dc1 >= 4'd8);
                    if (done) begin
                        if (r_phase == PH_HEX2) begin
                            w_job.cnt    = 3'd1;
                            w_job.res[0] = mk_data(hacc[7:0]);
                        end else begin
                            w_job = utf8(hacc);
                        end
                        n_phase = PH_BODY;
                        n_dc    = 4'd0;
                        n_acc   = 32'd0;
                    end
                end
            end
            default: n_phase = PH_HALT;
        endcase

        if (i_last) begin
            if (n_phase == PH_SEEK) begin
                w_job        = '0;
                w_job.cnt    = 3'd1;
                w_job.res[0] = mk_err(ERR_NO_OPEN);
            end else if (n_phase != PH_HALT) begin
                w_job        = '0;
                w_job.cnt    = 3'd1;
                w_job.res[0] = mk_err(ERR_NO_CLOSE);
            end
            n_phase = PH_SEEK;
            n_dc    = 4'd0;
            n_acc   = 32'd0;
            n_idx   = 32'd0;
        end
        w_job.pos = r_idx;
    end

    assign o_ready = !i_full;
    assign w_take  = i_valid && !i_full;
    assign o_push  = w_take && (w_job.cnt != 3'd0);
    assign o_job   = w_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEEK;
            r_dc    <= 4'd0;
            r_acc   <= 32'd0;
            r_idx   <= 32'd0;
        end else if (w_take) begin
            r_phase <= n_phase;
            r_dc    <= n_dc;
            r_acc   <= n_acc;
            r_idx   <= n_idx;
        end
    end

endmodule

// ----- rtl/qsud_queue.sv -----
// Job queue between the front end and the output serializer.
// Small register FIFO of job records. Depends on qsud_pkg.
module qsud_queue import qsud_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_job  i_job,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_job  o_head
);

    t_job                r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr, r_rd;
    logic [QPTR_W:0]     r_cnt;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + QPTR_W'(1);
            if (i_pop)  r_rd <= r_rd + QPTR_W'(1);
            if (i_push && !i_pop)      r_cnt <= r_cnt + (QPTR_W+1)'(1);
            else if (!i_push && i_pop) r_cnt <= r_cnt - (QPTR_W+1)'(1);
        end
    end

endmodule

// ----- rtl/qsud_back.sv -----
// Back end: walks the results of the head job one per cycle, while the output is not
// stalled, into a registered output stage. Depends on qsud_pkg.
module qsud_back import qsud_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_job        i_head,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output t_res        o_res,
    output logic [31:0] o_pos
);

    logic        r_valid;
    t_res        r_res;
    logic [31:0] r_pos;
    logic [1:0]  r_sub;
    logic        w_free, w_load, w_lastsub;

    assign w_free    = !r_valid || i_ready;
    assign w_load    = w_free && !i_empty;
    assign w_lastsub = ({1'b0, r_sub} == (i_head.cnt - 3'd1));
    assign o_pop     = w_load && w_lastsub;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 2'd0;
        end else begin
            if (w_free) r_valid <= !i_empty;
            if (w_load) r_sub <= w_lastsub ? 2'd0 : r_sub + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_res <= i_head.res[r_sub];
            r_pos <= i_head.pos;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
    assign o_pos   = r_pos;

endmodule

// ----- rtl/quoted_string_unescape_decoder_top.sv -----
// Quoted string unescape decoder, top level: APB registers, front end, job queue, back end.
// Depends on qsud_pkg, qsud_front, qsud_queue, qsud_back.
//
// Takes one source byte per cycle on the slave stream, however many results it causes,
// while the job queue is not full, and emits decoded string bytes, an end marker at the
// closing quote, or an error item on the master stream. A byte causing several results
// (octal flush plus the next character: two; a \u or \U escape: up to four UTF-8 bytes)
// holds the output serializer, so sustained rate is one result item per cycle while the
// master stream is ready; a four-entry job queue lets input keep flowing while the output
// stalls. No clearing pass after reset. Write registers only while the block is idle.
module quoted_string_unescape_decoder_top import qsud_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] src_byte
    input  logic        s_axis_tlast,   // is_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [7:0] data_byte, [10:8] error_code,
                                        // [42:11] position, [47:43] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]  r_quote;
    logic        r_allow;
    logic        w_push, w_full, w_pop, w_empty;
    t_job        w_job, w_head;
    t_res        w_res;
    logic [31:0] w_pos;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quote <= QUOTE_RESET;
            r_allow <= 1'b1;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                REG_QUOTE: r_quote <= pwdata[7:0];
                REG_ALLOW: r_allow <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_QUOTE: prdata = {24'd0, r_quote};
            REG_ALLOW: prdata = {31'd0, r_allow};
            default:   prdata = 32'd0;
        endcase
    end

    qsud_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_byte     (s_axis_tdata),
        .i_last     (s_axis_tlast),
        .i_quote    (r_quote),
        .i_allow_nl (r_allow),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_job      (w_job)
    );

    qsud_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    qsud_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (w_res),
        .o_pos   (w_pos)
    );

    assign m_axis_tdata = {5'd0, w_pos, w_res.err, w_res.data};
    assign m_axis_tuser = w_res.kind;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("job pushed into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("job popped from empty queue");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tuser == KIND_ERR) == (m_axis_tdata[10:8] != ERR_NONE)))
        else $error("error code does not match result kind");

    a_marker_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != KIND_DATA) |-> (m_axis_tdata[7:0] == 8'h00))
        else $error("end or error item carries data");

endmodule
